// File: hdl/nsc_pkg.sv
// Shared types, constants and prefix tables for the NMEA sentence capture block.
package nsc_pkg;

    localparam int MAX_LEN_DEF = 128;
    localparam int TAG_LEN     = 6;

    localparam logic [7:0] CHAR_DOLLAR = 8'h24;

    // Event codes reported with every result word.
    localparam logic [1:0] EV_NONE = 2'd0;
    localparam logic [1:0] EV_GGA  = 2'd1;
    localparam logic [1:0] EV_VTG  = 2'd2;

    // Input modes.
    localparam logic MODE_SERIAL = 1'b0;
    localparam logic MODE_READ   = 1'b1;

    // Bits of the prefix tracker.
    localparam int TRK_GGA_BIT = 0;
    localparam int TRK_VTG_BIT = 1;

    typedef struct packed {
        logic       mode;
        logic [7:0] rx_byte;
        logic       line_error;
        logic       which_sentence;
        logic [6:0] read_index;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  event_res;
        logic [15:0] gga_count;
        logic [15:0] vtg_count;
        logic [7:0]  read_byte;
        logic [7:0]  read_length;
    } t_out_item;

    function automatic logic [7:0] gga_tag(input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0: c = "$";
            3'd1: c = "G";
            3'd2: c = "P";
            3'd3: c = "G";
            3'd4: c = "G";
            3'd5: c = "A";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] vtg_tag(input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0: c = "$";
            3'd1: c = "G";
            3'd2: c = "P";
            3'd3: c = "V";
            3'd4: c = "T";
            3'd5: c = "G";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// File: hdl/nsc_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
module nsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 384
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/nmea_sentence_capture_top.sv
// Top level of the NMEA sentence capture block: parser, bank bookkeeping and result pipeline.
//
// Usage: every input word is either a received serial byte (mode 0) or a read of a
// stored sentence byte (mode 1). Each input word yields exactly one result word on the
// output channel, carrying the store event, both record counts and, for reads, the
// requested byte and the record length.
// Both channels use valid/stall; a word moves at a clock edge with valid high and
// stall low. Sentences are assembled in one RAM of three banks of MAX_LEN bytes; a
// stored GGA or VTG record is just a bank pointer swap, so nothing is copied.
// Throughput is one word per cycle unless the receiver stalls: the parser state lives in
// registers and each word makes at most one RAM access (a write for a kept serial byte,
// a read for a read word). An accepted word passes the registered RAM read stage and
// then the output register before it shows on o_out_valid.
// When the receiver stalls, the output register holds its word and the stage ahead of
// it holds too; the input stalls only once both are full.
// Reset (synchronous, active low) returns the parser to its start phase, the bank
// pointers to banks zero, one and two, and lengths and counts to zero. The RAM needs no
// clearing: only bytes written within a stored sentence are ever read back.
module nmea_sentence_capture_top
    import nsc_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    localparam int DEPTH = 3 * MAX_LEN;
    localparam int AW    = $clog2(DEPTH);
    localparam int FW    = $clog2(MAX_LEN + 1);

    typedef enum logic [1:0] {
        PH_START,
        PH_BODY,
        PH_DISCARD
    } t_phase;

    // Parser and bookkeeping state.
    t_phase        r_phase, n_phase;
    logic [FW-1:0] r_fill, n_fill;
    logic [FW-1:0] r_text_len, n_text_len;
    logic          r_zero_hit, n_zero_hit;
    logic [1:0]    r_trk, n_trk;
    logic [1:0]    r_ptr [0:2];
    logic [1:0]    n_ptr [0:2];
    logic [FW-1:0] r_len [0:1];
    logic [FW-1:0] n_len [0:1];
    logic [15:0]   r_cnt [0:1];
    logic [15:0]   n_cnt [0:1];

    // Pipeline stage that waits for the RAM read data.
    logic        r_s1_vld;
    logic [1:0]  r_s1_ev;
    logic [15:0] r_s1_gga;
    logic [15:0] r_s1_vtg;
    logic [7:0]  r_s1_rlen;
    logic        r_s1_hit;

    logic        r_out_vld;
    t_out_item   r_out;

    logic        out_free;
    logic        s1_free;
    logic        accept;
    logic [1:0]  ev;
    logic [7:0]  rlen;
    logic        hit;
    logic        ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]  ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [7:0]  ram_rdata;
    logic [1:0]  rd_bank;
    logic        do_close;
    logic        do_begin;
    logic        do_append;
    logic        is_dollar;
    logic [1:0]  swap_tmp;

    assign out_free   = !r_out_vld || !i_out_stall;
    assign s1_free    = !r_s1_vld || out_free;
    assign o_in_stall = !s1_free;
    assign accept     = i_in_valid && s1_free;
    assign is_dollar  = (i_in_data.rx_byte == CHAR_DOLLAR);

    always_comb begin
        n_phase    = r_phase;
        n_fill     = r_fill;
        n_text_len = r_text_len;
        n_zero_hit = r_zero_hit;
        n_trk      = r_trk;
        n_ptr      = r_ptr;
        n_len      = r_len;
        n_cnt      = r_cnt;
        ev         = EV_NONE;
        ram_we     = 1'b0;
        ram_waddr  = '0;
        ram_wdata  = i_in_data.rx_byte;
        do_close   = 1'b0;
        do_begin   = 1'b0;
        do_append  = 1'b0;
        swap_tmp   = '0;

        if (accept && i_in_data.mode == MODE_SERIAL) begin
            if (i_in_data.line_error) begin
                n_phase = PH_DISCARD;
            end else begin
                case (r_phase)
                    PH_START: begin
                        if (is_dollar) begin
                            do_begin = 1'b1;
                        end else begin
                            do_append = 1'b1;
                            n_phase   = PH_BODY;
                        end
                    end
                    PH_BODY: begin
                        if (is_dollar) begin
                            do_close = 1'b1;
                            do_begin = 1'b1;
                        end else begin
                            do_append = 1'b1;
                        end
                    end
                    PH_DISCARD: begin
                        do_begin = is_dollar;
                    end
                    default: begin
                        n_phase = PH_DISCARD;
                    end
                endcase
            end
        end

        // A qualifying sentence becomes the latest record by swapping its bank in.
        if (do_close && r_fill >= FW'(TAG_LEN) && r_trk != 2'b00) begin
            if (r_trk[TRK_GGA_BIT]) begin
                ev       = EV_GGA;
                swap_tmp = r_ptr[1];
                n_ptr[1] = r_ptr[0];
                n_len[0] = r_text_len;
                n_cnt[0] = r_cnt[0] + 16'd1;
            end else begin
                ev       = EV_VTG;
                swap_tmp = r_ptr[2];
                n_ptr[2] = r_ptr[0];
                n_len[1] = r_text_len;
                n_cnt[1] = r_cnt[1] + 16'd1;
            end
            n_ptr[0] = swap_tmp;
        end

        if (do_begin) begin
            ram_we     = 1'b1;
            ram_waddr  = AW'(n_ptr[0]) * AW'(MAX_LEN);
            ram_wdata  = CHAR_DOLLAR;
            n_fill     = FW'(1);
            n_text_len = FW'(1);
            n_zero_hit = 1'b0;
            n_trk      = 2'b11;
            n_phase    = PH_START;
        end

        // Bytes past MAX_LEN are dropped; the text length stops at the first zero byte.
        if (do_append && r_fill < FW'(MAX_LEN)) begin
            ram_we    = 1'b1;
            ram_waddr = AW'(r_ptr[0]) * AW'(MAX_LEN) + AW'(r_fill);
            n_fill    = r_fill + FW'(1);
            if (!r_zero_hit) begin
                if (i_in_data.rx_byte == 8'h00) begin
                    n_zero_hit = 1'b1;
                end else begin
                    n_text_len = r_fill + FW'(1);
                end
            end
            if (r_fill < FW'(TAG_LEN)) begin
                if (i_in_data.rx_byte != gga_tag(r_fill[2:0])) begin
                    n_trk[TRK_GGA_BIT] = 1'b0;
                end
                if (i_in_data.rx_byte != vtg_tag(r_fill[2:0])) begin
                    n_trk[TRK_VTG_BIT] = 1'b0;
                end
            end
        end
    end

    // Read side: stored records live in the banks named by pointers one and two.
    assign rd_bank   = i_in_data.which_sentence ? r_ptr[2] : r_ptr[1];
    assign ram_raddr = AW'(rd_bank) * AW'(MAX_LEN) + AW'(i_in_data.read_index);
    assign rlen      = (i_in_data.mode == MODE_READ) ? 8'(r_len[i_in_data.which_sentence]) : 8'd0;
    assign hit       = (i_in_data.mode == MODE_READ)
                    && (32'(i_in_data.read_index) < 32'(r_len[i_in_data.which_sentence]));

    nsc_ram #(
        .WIDTH(8),
        .DEPTH(DEPTH)
    ) u_bank_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (accept && i_in_data.mode == MODE_READ),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_START;
            r_fill     <= FW'(1);
            r_text_len <= '0;
            r_zero_hit <= 1'b1;
            r_trk      <= 2'b00;
            r_ptr[0]   <= 2'd0;
            r_ptr[1]   <= 2'd1;
            r_ptr[2]   <= 2'd2;
            r_len[0]   <= '0;
            r_len[1]   <= '0;
            r_cnt[0]   <= '0;
            r_cnt[1]   <= '0;
            r_s1_vld   <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_fill     <= n_fill;
            r_text_len <= n_text_len;
            r_zero_hit <= n_zero_hit;
            r_trk      <= n_trk;
            r_ptr      <= n_ptr;
            r_len      <= n_len;
            r_cnt      <= n_cnt;
            if (s1_free) begin
                r_s1_vld <= i_in_valid;
            end
            if (out_free) begin
                r_out_vld <= r_s1_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_ev   <= ev;
            r_s1_gga  <= n_cnt[0];
            r_s1_vtg  <= n_cnt[1];
            r_s1_rlen <= rlen;
            r_s1_hit  <= hit;
        end
        if (out_free && r_s1_vld) begin
            r_out.event_res   <= r_s1_ev;
            r_out.gga_count   <= r_s1_gga;
            r_out.vtg_count   <= r_s1_vtg;
            r_out.read_byte   <= r_s1_hit ? ram_rdata : 8'd0;
            r_out.read_length <= r_s1_rlen;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // The three bank pointers always name three different banks.
    a_ptr_distinct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ptr[0] != r_ptr[1]) && (r_ptr[0] != r_ptr[2]) && (r_ptr[1] != r_ptr[2]))
        else $error("bank pointers collide");

    // The fill position never passes the bank size, and the text never passes the fill.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill <= FW'(MAX_LEN)) && (r_fill != '0) && (r_text_len <= r_fill))
        else $error("fill count out of range");

    // A GGA store bumps only the GGA count.
    a_gga_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && ev == EV_GGA) |=> (r_cnt[0] == $past(r_cnt[0]) + 16'd1)
            && (r_cnt[1] == $past(r_cnt[1])))
        else $error("GGA store did not advance its count");

    // Input is held back only while the read-data stage is occupied and cannot move.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_s1_vld && r_out_vld && i_out_stall))
        else $error("input stalled without a full pipeline");

    // A word in the read-data stage reaches the output register when it is free.
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && out_free) |=> r_out_vld)
        else $error("pipeline word lost");

endmodule

// File: dv/nmea_sentence_capture_top_tb.sv
// Self-checking testbench for the NMEA sentence capture block: directed table, then random words.
module nmea_sentence_capture_top_tb;
    import nsc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_LEN = MAX_LEN_DEF;
    localparam int RAND_WORDS = 800;
    localparam int HOLD_CYCLES = 60;
    localparam int DIR_ROWS = 26;
    localparam logic [47:0] GGA_TAG = "$GPGGA";
    localparam logic [47:0] VTG_TAG = "$GPVTG";
    localparam t_out_item NO_RES = '{EV_NONE, 16'd0, 16'd0, 8'd0, 8'd0};

    typedef enum logic [1:0] {PH_START, PH_BODY, PH_DISCARD} t_parse_phase;

    // One input word, plus the result typed in for it where it is obvious.
    typedef struct packed {
        t_in_item  w;
        logic      fixed;
        t_out_item exp;
    } t_stim_word;

    localparam t_stim_word DIR_TAB [DIR_ROWS] = '{
        '{'{MODE_READ,   8'hFF,       1'b1, 1'b0, 7'd127}, 1'b1, NO_RES},
        '{'{MODE_READ,   8'h00,       1'b0, 1'b1, 7'd0},   1'b1, NO_RES},
        '{'{MODE_SERIAL, "X",         1'b0, 1'b0, 7'd0},   1'b1, NO_RES},
        '{'{MODE_SERIAL, 8'hFF,       1'b1, 1'b0, 7'd0},   1'b1, NO_RES},
        '{'{MODE_SERIAL, "A",         1'b0, 1'b0, 7'd0},   1'b1, NO_RES},
        '{'{MODE_SERIAL, CHAR_DOLLAR, 1'b0, 1'b0, 7'd0},   1'b1, NO_RES},
        '{'{MODE_SERIAL, CHAR_DOLLAR, 1'b0, 1'b0, 7'd0},   1'b0, NO_RES},
        '{'{MODE_SERIAL, "G",         1'b0, 1'b0, 7'd0},   1'b0, NO_RES},
        '{'{MODE_SERIAL, "P",         1'b0, 1'b0, 7'd0},   1'b0, NO_RES},
        '{'{MODE_SERIAL, "G",         1'b0, 1'b0, 7'd0},   1'b0, NO_RES},
        '{'{MODE_SERIAL, "G",         1'b0, 1'b0, 7'd0},   1'b0, NO_RES},
        '{'{MODE_SERIAL, "A",         1'b0, 1'b0, 7'd0},   1'b0, NO_RES},
        '{'{MODE_SERIAL, 8'h00,       1'b0, 1'b0, 7'd0},   1'b0, NO_RES},
        '{'{MODE_SERIAL, ",",         1'b0, 1'b0, 7'd0},   1'b0, NO_RES},
        '{'{MODE_SERIAL, CHAR_DOLLAR, 1'b0, 1'b0, 7'd0},   1'b1,
            '{EV_GGA, 16'd1, 16'd0, 8'd0, 8'd0}},
        '{'{MODE_READ,   8'h00,       1'b0, 1'b0, 7'd5},   1'b0, NO_RES},
        '{'{MODE_READ,   8'h00,       1'b0, 1'b0, 7'd6},   1'b1,
            '{EV_NONE, 16'd1, 16'd0, 8'd0, 8'd6}},
        '{'{MODE_SERIAL, "G",         1'b0, 1'b0, 7'd0},   1'b0, NO_RES},
        '{'{MODE_SERIAL, "P",         1'b0, 1'b0, 7'd0},   1'b0, NO_RES},
        '{'{MODE_SERIAL, "V",         1'b0, 1'b0, 7'd0},   1'b0, NO_RES},
        '{'{MODE_SERIAL, "T",         1'b0, 1'b0, 7'd0},   1'b0, NO_RES},
        '{'{MODE_SERIAL, "G",         1'b0, 1'b0, 7'd0},   1'b0, NO_RES},
        '{'{MODE_SERIAL, CHAR_DOLLAR, 1'b0, 1'b0, 7'd0},   1'b1,
            '{EV_VTG, 16'd1, 16'd1, 8'd0, 8'd0}},
        '{'{MODE_SERIAL, "G",         1'b0, 1'b0, 7'd0},   1'b0, NO_RES},
        '{'{MODE_SERIAL, CHAR_DOLLAR, 1'b0, 1'b0, 7'd0},   1'b0, NO_RES},
        '{'{MODE_READ,   8'h00,       1'b0, 1'b1, 7'd0},   1'b0, NO_RES}
    };

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_data = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_data;

    nmea_sentence_capture_top i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Predicted parser and record state.
    t_parse_phase phase;
    int           fill_cnt;
    logic [7:0]   sent_mem [3*MAX_LEN];
    logic [1:0]   trk;
    int           bank_ptr [3];
    int           rec_len [2];
    logic [15:0]  rec_cnt [2];
    int           text_len;
    logic         zero_seen;

    t_stim_word stim_q [$];
    t_out_item  result_q [$];
    logic       cur_fixed = 1'b0;
    t_out_item  cur_exp = '0;
    int         n_total = 0;
    int         in_count = 0;
    int         err_cnt = 0;
    int         n_checked = 0;
    int         n_gga = 0;
    int         n_vtg = 0;
    int         n_reads = 0;
    int         in_stall_cycles = 0;
    int         hold_left = 0;
    logic       hold_done = 1'b0;

    function automatic void open_sentence();
        sent_mem[bank_ptr[0]*MAX_LEN] = CHAR_DOLLAR;
        fill_cnt = 1;
        text_len = 1;
        zero_seen = 1'b0;
        trk = 2'b11;
        phase = PH_START;
    endfunction

    function automatic void add_byte(input logic [7:0] b);
        int p;
        p = fill_cnt;
        if (p >= MAX_LEN) begin
            return;
        end
        sent_mem[bank_ptr[0]*MAX_LEN + p] = b;
        fill_cnt = p + 1;
        // The stored length stops growing at the first zero byte.
        if (!zero_seen) begin
            if (b == 8'h00) begin
                zero_seen = 1'b1;
            end else begin
                text_len = p + 1;
            end
        end
        if (p < TAG_LEN) begin
            if (b != GGA_TAG[47 - 8*p -: 8]) trk[TRK_GGA_BIT] = 1'b0;
            if (b != VTG_TAG[47 - 8*p -: 8]) trk[TRK_VTG_BIT] = 1'b0;
        end
    endfunction

    function automatic logic [1:0] close_sentence();
        int k;
        int t;
        if (fill_cnt < TAG_LEN || trk == 2'b00) begin
            return EV_NONE;
        end
        k = trk[TRK_GGA_BIT] ? 1 : 2;
        t = bank_ptr[k];
        bank_ptr[k] = bank_ptr[0];
        bank_ptr[0] = t;
        rec_len[k-1] = text_len;
        rec_cnt[k-1] = rec_cnt[k-1] + 16'd1;
        return (k == 1) ? EV_GGA : EV_VTG;
    endfunction

    function automatic t_out_item capture_step(input t_in_item w);
        t_out_item r;
        int sel;
        r = '0;
        sel = int'(w.which_sentence);
        if (w.mode == MODE_SERIAL) begin
            if (w.line_error) begin
                phase = PH_DISCARD;
            end else begin
                case (phase)
                    PH_START: begin
                        if (w.rx_byte == CHAR_DOLLAR) begin
                            open_sentence();
                        end else begin
                            add_byte(w.rx_byte);
                            phase = PH_BODY;
                        end
                    end
                    PH_BODY: begin
                        if (w.rx_byte == CHAR_DOLLAR) begin
                            r.event_res = close_sentence();
                            open_sentence();
                        end else begin
                            add_byte(w.rx_byte);
                        end
                    end
                    default: begin
                        if (w.rx_byte == CHAR_DOLLAR) open_sentence();
                    end
                endcase
            end
        end else begin
            r.read_length = rec_len[sel][7:0];
            if (int'(w.read_index) < rec_len[sel]) begin
                r.read_byte = sent_mem[bank_ptr[sel+1]*MAX_LEN + int'(w.read_index)];
            end
        end
        r.gga_count = rec_cnt[0];
        r.vtg_count = rec_cnt[1];
        return r;
    endfunction

    task automatic push_ser(input logic [7:0] b, input logic err);
        t_stim_word x;
        x = '0;
        x.w.mode = MODE_SERIAL;
        x.w.rx_byte = b;
        x.w.line_error = err;
        x.w.which_sentence = 1'($urandom_range(0, 1));
        x.w.read_index = 7'($urandom_range(0, 127));
        stim_q.push_back(x);
    endtask

    task automatic push_read(input logic sel, input logic [6:0] idx);
        t_stim_word x;
        x = '0;
        x.w.mode = MODE_READ;
        x.w.rx_byte = 8'($urandom_range(0, 255));
        x.w.line_error = 1'($urandom_range(0, 1));
        x.w.which_sentence = sel;
        x.w.read_index = idx;
        stim_q.push_back(x);
    endtask

    // A sentence with a real, near-miss or junk prefix and a body of random length;
    // the next sentence's dollar sign closes it.
    task automatic add_sentence();
        int pick;
        int tag_n;
        int body_len;
        int bad_pos;
        int r;
        logic [47:0] tag;
        pick = $urandom_range(0, 99);
        tag_n = TAG_LEN;
        if (pick < 40) begin
            tag = GGA_TAG;
        end else if (pick < 80) begin
            tag = VTG_TAG;
        end else if (pick < 90) begin
            tag = $urandom_range(0, 1) ? GGA_TAG : VTG_TAG;
            bad_pos = $urandom_range(1, 5);
            tag[47 - 8*bad_pos -: 8] = 8'($urandom_range(0, 255));
        end else begin
            tag = 48'({$urandom, $urandom});
            tag[47:40] = CHAR_DOLLAR;
            tag_n = $urandom_range(1, TAG_LEN);
        end
        for (int i = 0; i < tag_n; i++) begin
            push_ser(tag[47 - 8*i -: 8], 1'b0);
        end
        body_len = ($urandom_range(0, 11) == 0) ? $urandom_range(115, 140)
                                                 : $urandom_range(0, 30);
        for (int i = 0; i < body_len; i++) begin
            r = $urandom_range(0, 99);
            if (r < 3) begin
                push_ser(8'h00, 1'b0);
            end else if (r < 5) begin
                push_ser(8'($urandom_range(0, 255)), 1'b1);
            end else begin
                push_ser(8'($urandom_range(8'h25, 8'h7E)), 1'b0);
            end
        end
    endtask

    task automatic cmp_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_cnt++;
        end
    endtask

    // Sender: offers words, holds a stalled word, and predicts each accepted one.
    always @(posedge i_clk) begin
        t_stim_word nxt;
        t_out_item r;
        int ph;
        int idle_pct;
        ph = (in_count * 5) / ((n_total == 0) ? 1 : n_total);
        idle_pct = (ph == 1) ? 56 : (ph == 3) ? 14 : 0;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                r = capture_step(i_in_data);
                if (cur_fixed) r = cur_exp;
                result_q.push_back(r);
                if (i_in_data.mode == MODE_READ) n_reads++;
                in_count++;
            end else if (i_in_valid) begin
                in_stall_cycles++;
            end
            if (i_in_valid && o_in_stall) begin
                // A stalled word stays on the bus unchanged.
            end else if (stim_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
                nxt = stim_q.pop_front();
                i_in_valid <= 1'b1;
                i_in_data <= nxt.w;
                cur_fixed <= nxt.fixed;
                cur_exp <= nxt.exp;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off late in the run to fill the pipeline.
    always @(posedge i_clk) begin
        int ph;
        int stall_pct;
        ph = (in_count * 5) / ((n_total == 0) ? 1 : n_total);
        stall_pct = (ph == 2) ? 56 : (ph == 3) ? 14 : 0;
        if (hold_left != 0) begin
            i_out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (!hold_done && n_total != 0 && in_count >= n_total * 4 / 5 + 20) begin
            i_out_stall <= 1'b1;
            hold_left <= HOLD_CYCLES - 1;
            hold_done <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            n_checked++;
            if (o_out_data.event_res == EV_GGA) n_gga++;
            if (o_out_data.event_res == EV_VTG) n_vtg++;
            if (result_q.size() == 0) begin
                $error("result word arrived with nothing expected");
                err_cnt++;
            end else begin
                want = result_q.pop_front();
                cmp_field("event_res", 16'(want.event_res), 16'(o_out_data.event_res));
                cmp_field("gga_count", want.gga_count, o_out_data.gga_count);
                cmp_field("vtg_count", want.vtg_count, o_out_data.vtg_count);
                cmp_field("read_byte", 16'(want.read_byte), 16'(o_out_data.read_byte));
                cmp_field("read_length", 16'(want.read_length),
                          16'(o_out_data.read_length));
            end
        end
    end

    initial begin
        int pick;
        int n;
        phase = PH_START;
        fill_cnt = 1;
        text_len = 0;
        zero_seen = 1'b1;
        trk = 2'b00;
        for (int i = 0; i < 3; i++) bank_ptr[i] = i;
        for (int i = 0; i < 2; i++) begin
            rec_len[i] = 0;
            rec_cnt[i] = 16'd0;
        end
        foreach (sent_mem[i]) sent_mem[i] = 8'h00;

        foreach (DIR_TAB[i]) stim_q.push_back(DIR_TAB[i]);
        while (stim_q.size() < DIR_ROWS + RAND_WORDS) begin
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
                add_sentence();
            end else if (pick < 85) begin
                n = $urandom_range(1, 4);
                repeat (n) begin
                    if ($urandom_range(0, 3) == 0) begin
                        push_read(1'($urandom_range(0, 1)), 7'($urandom_range(96, 127)));
                    end else if ($urandom_range(0, 1) == 0) begin
                        push_read(1'($urandom_range(0, 1)), 7'($urandom_range(0, 127)));
                    end else begin
                        push_read(1'($urandom_range(0, 1)), 7'($urandom_range(0, 15)));
                    end
                end
            end else begin
                n = $urandom_range(1, 6);
                repeat (n) push_ser(8'($urandom_range(0, 255)), $urandom_range(0, 9) < 3);
            end
        end
        // Close the last sentence and look at both records once more.
        push_ser(CHAR_DOLLAR, 1'b0);
        push_read(1'b0, 7'($urandom_range(0, 7)));
        push_read(1'b1, 7'($urandom_range(0, 7)));
        n_total = stim_q.size();

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (in_count != n_total || result_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("Sent %0d words (%0d reads); checked %0d results", in_count, n_reads, n_checked);
        $display("with %0d GGA and %0d VTG stores; input held off for %0d cycles.",
                 n_gga, n_vtg, in_stall_cycles);
        if (err_cnt == 0) begin
            $display("nmea_sentence_capture_top_tb OK");
        end else begin
            $display("nmea_sentence_capture_top_tb NOT OK");
        end
        $finish;
    end

    initial begin
        #400_000;
        $display("nmea_sentence_capture_top_tb NOT OK");
        $finish;
    end

endmodule
